>>> rtl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, muted while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds through reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/rzgf_pkg.sv
package rzgf_pkg;

  localparam int MAX_STEP  = 8;
  localparam int WIN_DEPTH = 2 * MAX_STEP + 1;
  localparam int POS_W     = $clog2(MAX_STEP + 1);
  localparam int BYTE_W    = 8;
  localparam int CFG_W     = 4;
  localparam int CNT_W     = 16;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [POS_W-1:0]  pos_t;

  typedef struct packed {
    byte_t value;
    logic  filled;
  } pick_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

>>> rtl/rzgf_cell.sv
module rzgf_cell import rzgf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  byte_t      in_byte,
  input  logic       in_valid,
  output byte_t      cell_byte,
  output logic       cell_valid
);

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      cell_byte <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid <= 1'b0;
    end else if (ctrl.shift) begin
      cell_valid <= in_valid;
    end else if (ctrl.clear) begin
      cell_valid <= 1'b0;
    end
  end

endmodule

>>> rtl/rzgf_pick.sv
module rzgf_pick import rzgf_pkg::*; (
  input  byte_t                center,
  input  byte_t [MAX_STEP-1:0] rt_bytes,
  input  logic  [MAX_STEP-1:0] rt_valid,
  input  byte_t [MAX_STEP-1:0] lf_bytes,
  input  logic  [MAX_STEP-1:0] lf_valid,
  input  pos_t                 step,
  output pick_t                res
);

  always_comb begin
    res.value  = center;
    res.filled = 1'b0;
    if (center == '0) begin
      // walk inward so the nearest hit wins; right beats left at equal distance
      for (int j = MAX_STEP; j >= 1; j--) begin
        if (POS_W'(j) <= step) begin
          if (lf_valid[j-1] && lf_bytes[j-1] != '0) begin
            res.value  = lf_bytes[j-1];
            res.filled = 1'b1;
          end
          if (rt_valid[j-1] && rt_bytes[j-1] != '0) begin
            res.value  = rt_bytes[j-1];
            res.filled = 1'b1;
          end
        end
      end
    end
  end

endmodule

>>> rtl/row_zero_gap_fill.sv
// Order: a byte's request is registered on the beat that brings its max_step-th right
//   neighbor, then its result is registered out; a row end releases the rest alike.
// Throughput, while the output is not stalled: one beat per cycle inside a row; a row end
//   emits its remaining pending results (up to MAX_STEP + 1) one per cycle, input held meanwhile.
// Reset: synchronous rst clears the window valid bits, counters and output valid;
//   max_step returns to 1.
module row_zero_gap_fill import rzgf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,   // [7:0] sample
  input  logic             s_tlast,   // row_end
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [23:0]      m_tdata,   // [7:0] value, [23:8] fill_count
  output logic [0:0]       m_tuser,   // [0] was_filled
  output logic             m_tlast,   // row_last
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data   // max_step
);

  logic [CFG_W-1:0]     cfg_step;
  pos_t                 step;
  pos_t                 pending, pending_next;
  logic                 req_valid, req_valid_next;
  pos_t                 req_idx, req_idx_next;
  logic                 req_last, req_last_next;
  logic                 req_flush, req_flush_next;
  logic [CNT_W-1:0]     fills, fills_inc;
  logic                 acc, emit_fire;
  cell_ctrl_t           ctrl;
  byte_t                win_byte [WIN_DEPTH];
  logic [WIN_DEPTH-1:0] win_valid;
  pick_t                picks [MAX_STEP+1];
  pick_t                sel;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_step <= CFG_W'(1);
    end else if (cfg_valid) begin
      cfg_step <= cfg_data;
    end
  end

  always_comb begin
    if (cfg_step == '0) begin
      step = POS_W'(1);
    end else if (int'(cfg_step) > MAX_STEP) begin
      step = POS_W'(MAX_STEP);
    end else begin
      step = POS_W'(cfg_step);
    end
  end

  assign emit_fire  = req_valid && (!m_tvalid || m_tready);
  assign s_tready   = !req_valid || (emit_fire && !(req_flush && !req_last));
  assign acc        = s_tvalid && s_tready;
  assign ctrl.shift = acc;
  assign ctrl.clear = emit_fire && req_last;

  // window cells, index 0 newest
  for (genvar k = 0; k < WIN_DEPTH; k++) begin : g_cell
    byte_t in_b;
    logic  in_v;
    if (k == 0) begin : g_head
      assign in_b = s_tdata;
      assign in_v = 1'b1;
    end else begin : g_link
      assign in_b = win_byte[k-1];
      assign in_v = win_valid[k-1] && !ctrl.clear;
    end
    rzgf_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .in_byte    (in_b),
      .in_valid   (in_v),
      .cell_byte  (win_byte[k]),
      .cell_valid (win_valid[k])
    );
  end

  // one search per position a result can leave from
  for (genvar k = 0; k <= MAX_STEP; k++) begin : g_pick
    byte_t [MAX_STEP-1:0] rt_b, lf_b;
    logic  [MAX_STEP-1:0] rt_v, lf_v;
    for (genvar j = 1; j <= MAX_STEP; j++) begin : g_tap
      if (k >= j) begin : g_rt
        assign rt_b[j-1] = win_byte[k-j];
        assign rt_v[j-1] = win_valid[k-j];
      end else begin : g_rt_none
        assign rt_b[j-1] = '0;
        assign rt_v[j-1] = 1'b0;
      end
      assign lf_b[j-1] = win_byte[k+j];
      assign lf_v[j-1] = win_valid[k+j];
    end
    rzgf_pick u_pick (
      .center   (win_byte[k]),
      .rt_bytes (rt_b),
      .rt_valid (rt_v),
      .lf_bytes (lf_b),
      .lf_valid (lf_v),
      .step     (step),
      .res      (picks[k])
    );
  end

  assign sel       = picks[req_idx];
  assign fills_inc = (sel.filled && fills != '1) ? fills + CNT_W'(1) : fills;

  always_comb begin
    pending_next   = pending;
    req_valid_next = req_valid;
    req_idx_next   = req_idx;
    req_last_next  = req_last;
    req_flush_next = req_flush;
    if (emit_fire && req_flush && !req_last) begin
      // step down through the rest of the row
      req_idx_next  = req_idx - POS_W'(1);
      req_last_next = (req_idx == POS_W'(1));
    end else if (acc) begin
      req_idx_next = pending;
      if (s_tlast) begin
        req_valid_next = 1'b1;
        req_flush_next = 1'b1;
        req_last_next  = (pending == '0);
        pending_next   = '0;
      end else begin
        req_flush_next = 1'b0;
        req_last_next  = 1'b0;
        if (pending >= step) begin
          req_valid_next = 1'b1;
        end else begin
          req_valid_next = 1'b0;
          pending_next   = pending + POS_W'(1);
        end
      end
    end else if (emit_fire) begin
      req_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= '0;
      req_valid <= 1'b0;
      req_idx   <= '0;
      req_last  <= 1'b0;
      req_flush <= 1'b0;
      fills     <= '0;
    end else begin
      pending   <= pending_next;
      req_valid <= req_valid_next;
      req_idx   <= req_idx_next;
      req_last  <= req_last_next;
      req_flush <= req_flush_next;
      if (emit_fire) begin
        fills <= req_last ? '0 : fills_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      m_tdata[7:0]  <= sel.value;
      m_tdata[23:8] <= req_last ? fills_inc : '0;
      m_tuser[0]    <= sel.filled;
      m_tlast       <= req_last;
    end
  end

endmodule

>>> rtl/rzgf_checker.sv
`include "assert_macros.svh"

module rzgf_checker import rzgf_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic [7:0]       s_tdata,
  input logic             s_tlast,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [23:0]      m_tdata,
  input logic [0:0]       m_tuser,
  input logic             m_tlast,
  input logic             cfg_valid,
  input logic             cfg_ready,
  input logic [CFG_W-1:0] cfg_data
);

  // hold a stalled result beat
  `ASSERT_CLK(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result beat changed")

  `ASSERT_CLK(a_count_only_last, clk, rst, m_tvalid && !m_tlast |-> m_tdata[23:8] == 16'd0, "fill count on a non-last beat")

  `ASSERT_CLK(a_fill_nonzero, clk, rst, m_tvalid && m_tuser[0] |-> m_tdata[7:0] != 8'd0, "filled beat carries zero")

  `ASSERT_ALWAYS(a_reset_idle, clk, $past(rst) |-> !m_tvalid, "result valid right after reset")

endmodule

bind row_zero_gap_fill rzgf_checker u_rzgf_checker (.*);

>>> tb/row_zero_gap_fill_test.sv
`timescale 1ns / 1ps

typedef struct {
  rzgf_pkg::byte_t             value;
  bit                          filled;
  bit                          last;
  logic [rzgf_pkg::CNT_W-1:0]  count;
} fill_result_t;

class gap_fill_board;
  rzgf_pkg::byte_t             win_byte [rzgf_pkg::WIN_DEPTH];
  bit                          win_live [rzgf_pkg::WIN_DEPTH];
  int unsigned                 row_fills;
  int unsigned                 pending;
  logic [rzgf_pkg::CFG_W-1:0]  step_reg;
  fill_result_t                due_q [$];
  int unsigned                 errors;

  function new();
    foreach (win_byte[i]) begin
      win_byte[i] = '0;
      win_live[i] = 1'b0;
    end
    row_fills = 0;
    pending   = 0;
    step_reg  = 1;
    errors    = 0;
  endfunction

  function void set_step(logic [rzgf_pkg::CFG_W-1:0] v);
    step_reg = v;
  endfunction

  // Clamp the programmed step into 1..MAX_STEP.
  function int unsigned reach();
    int unsigned d;
    d = step_reg;
    if (d < 1) d = 1;
    if (d > rzgf_pkg::MAX_STEP) d = rzgf_pkg::MAX_STEP;
    return d;
  endfunction

  // Fill window entry c: at each distance try the later byte first.
  function void fill_entry(int unsigned c, int unsigned d, bit last);
    fill_result_t r;
    int unsigned  j;
    r.value  = win_byte[c];
    r.filled = 1'b0;
    if (r.value == 0) begin
      for (j = 1; j <= d && !r.filled; j++) begin
        if (c >= j && win_live[c-j] && win_byte[c-j] != 0) begin
          r.value  = win_byte[c-j];
          r.filled = 1'b1;
        end else if (c + j < rzgf_pkg::WIN_DEPTH && win_live[c+j] &&
                     win_byte[c+j] != 0) begin
          r.value  = win_byte[c+j];
          r.filled = 1'b1;
        end
      end
    end
    if (r.filled && row_fills < 65535) row_fills++;
    r.last  = last;
    r.count = last ? row_fills[rzgf_pkg::CNT_W-1:0] : '0;
    due_q.push_back(r);
  endfunction

  function void note_byte(rzgf_pkg::byte_t s, bit row_end);
    int unsigned d;
    int unsigned p;
    int unsigned i;
    d = reach();
    for (i = rzgf_pkg::WIN_DEPTH - 1; i > 0; i--) begin
      win_byte[i] = win_byte[i-1];
      win_live[i] = win_live[i-1];
    end
    win_byte[0] = s;
    win_live[0] = 1'b1;
    p = pending + 1;
    if (p > rzgf_pkg::MAX_STEP + 1) p = rzgf_pkg::MAX_STEP + 1;
    if (p > d) begin
      fill_entry(p - 1, d, row_end && p == 1);
      p--;
    end
    // flush the rest of the row on its last byte
    if (row_end) begin
      for (i = p; i > 0; i--) fill_entry(i - 1, d, i == 1);
      foreach (win_live[k]) win_live[k] = 1'b0;
      row_fills = 0;
      p = 0;
    end
    pending = p;
  endfunction

  function void check_result(rzgf_pkg::byte_t v, bit f, bit l,
                             logic [rzgf_pkg::CNT_W-1:0] c);
    fill_result_t e;
    if (due_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected beat: value %0d filled %0d last %0d count %0d",
                 v, f, l, c);
      return;
    end
    e = due_q.pop_front();
    if (e.value !== v || e.filled !== f || e.last !== l || e.count !== c) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: value %0d/%0d filled %0d/%0d last %0d/%0d count %0d/%0d",
                 e.value, v, e.filled, f, e.last, l, e.count, c);
    end
  endfunction

  function int unsigned failures();
    return errors + due_q.size();
  endfunction
endclass

module row_zero_gap_fill_test;
  import rzgf_pkg::*;

  localparam int SETTLE      = 4 * MAX_STEP + 8;
  localparam int STUCK_LIMIT = 2000;
  localparam int PHASE_ITEMS = 9;
  localparam int GAP_TRIPLES = 2;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [7:0]       s_tdata;
  logic             s_tlast;
  logic             m_tvalid;
  logic             m_tready;
  logic [23:0]      m_tdata;
  logic [0:0]       m_tuser;
  logic             m_tlast;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data;

  gap_fill_board board;
  bit            calm;
  int            hold_request;
  int            stuck_cycles;

  row_zero_gap_fill u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, a requested long hold-off, or always ready.
  initial begin
    int hold_left;
    hold_left = 0;
    m_tready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (calm) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= 14);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) board.set_step(cfg_data);
      if (s_tvalid && s_tready) board.note_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready)
        board.check_result(m_tdata[7:0], m_tuser[0], m_tlast, m_tdata[23:8]);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_byte(input byte_t s, input bit row_end);
    if (!calm && $urandom_range(0, 99) < 14) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= s;
    s_tlast  <= row_end;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Drain expected results and let pending work settle before the write.
  task automatic write_step(input logic [CFG_W-1:0] v);
    s_tvalid <= 1'b0;
    while (board.due_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic byte_t random_sample(bit sparse);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (sparse) return (r < 70) ? 8'd0 : byte_t'($urandom_range(1, 255));
    if (r < 25) return 8'd0;
    if (r < 30) return 8'd255;
    return byte_t'($urandom_range(1, 255));
  endfunction

  function automatic logic [CFG_W-1:0] step_for_phase(int unsigned ph);
    case (ph)
      0:       return 4'd8;
      1:       return 4'd9;
      2:       return 4'd2;
      3:       return 4'd5;
      4:       return 4'd1;
      5:       return 4'd3;
      6:       return 4'($urandom_range(0, 15));
      default: return 4'd8;
    endcase
  endfunction

  initial begin
    int unsigned k;
    int unsigned ph;
    bit          sparse;
    bit          row_open;
    bit          row_end;

    board        = new();
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tlast      = 1'b0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    calm         = 1'b0;
    hold_request = 0;
    sparse       = 1'b0;
    row_open     = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // step 0 acts as 1
    write_step(4'd0);
    // one-byte rows, zero with no neighbor and full scale
    send_byte(8'd0, 1'b1);
    send_byte(8'd255, 1'b1);
    // equal distance: right neighbor wins
    send_byte(8'd3, 1'b0);
    send_byte(8'd0, 1'b0);
    send_byte(8'd9, 1'b1);
    // zeros out of reach stay zero
    send_byte(8'd0, 1'b0);
    send_byte(8'd0, 1'b0);
    send_byte(8'd0, 1'b0);
    send_byte(8'd200, 1'b1);
    send_byte(8'd1, 1'b0);
    send_byte(8'd0, 1'b0);
    send_byte(8'd0, 1'b0);
    send_byte(8'd0, 1'b0);
    send_byte(8'd0, 1'b1);
    // step above the maximum clamps to MAX_STEP
    write_step(4'd15);
    for (k = 0; k < 10; k++) send_byte(8'd0, 1'b0);
    send_byte(8'd128, 1'b1);

    // row of paired gaps at step 1
    write_step(4'd1);
    calm = 1'b1;
    for (k = 0; k < GAP_TRIPLES; k++) begin
      send_byte(byte_t'($urandom_range(1, 255)), 1'b0);
      send_byte(8'd0, 1'b0);
      send_byte(8'd0, k == GAP_TRIPLES - 1);
    end
    calm = 1'b0;

    // random rows; phases may end mid-row so the step changes inside a row
    for (ph = 0; ph < 8; ph++) begin
      write_step(step_for_phase(ph));
      calm = (ph >= 3 && ph <= 5);
      if (ph == 2) hold_request = 80;
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (!row_open) begin
          sparse   = $urandom_range(0, 1);
          row_open = 1'b1;
        end
        row_end = ($urandom_range(0, 7) == 0) || (ph == 7 && k == PHASE_ITEMS - 1);
        send_byte(random_sample(sparse), row_end);
        if (row_end) row_open = 1'b0;
      end
      calm = 1'b0;
    end

    s_tvalid <= 1'b0;
    while (board.due_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (board.failures() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
